FILE: sv/scpf_pkg.sv
`default_nettype none
package scpf_pkg;

  localparam int GROUP_CAPACITY_DEF = 32;

  localparam int POS_W     = 24;
  localparam int RAD_W     = 20;
  localparam int LAYER_W   = 32;
  localparam int DMG_W     = 16;
  localparam int OUT_IDX_W = 5;

  localparam int DIFF_W = POS_W + 1;
  localparam int SQ_W   = 2 * POS_W + 1;
  localparam int DSQ_W  = SQ_W + 1;
  localparam int RSUM_W = RAD_W + 1;
  localparam int RSQ_W  = 2 * RSUM_W;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [RAD_W-1:0]        radius;
    logic [LAYER_W-1:0]      attribute;
    logic [LAYER_W-1:0]      mask;
    logic [DMG_W-1:0]        damage;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic final_pair;
  } pair_ctl_t;

  typedef struct packed {
    logic             valid;
    logic             final_pair;
    logic             hit;
    logic [DMG_W-1:0] damage;
  } pair_res_t;

endpackage
`default_nettype wire

FILE: sv/sphere_collision_pair_filter.sv
// Insert: tests the new collider against the n stored colliders of its group, one pair per
// cycle unless the output stalls, through the shared pair-test pipeline (read, a, b, result
// registers); the next input waits until the walk has drained and no result is pending.
// Full-group insert: a group_full result only; clear and insert into an empty group: no result.
// Backpressure on the results stalls the walk and the pair-test pipeline.
// Reset clears the group counts and control; collider memory is not cleared.
`default_nettype none
module sphere_collision_pair_filter #(
  parameter int GROUP_CAPACITY = scpf_pkg::GROUP_CAPACITY_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic                                    in_opcode,
  input  wire logic                                    in_group,
  input  wire logic signed [scpf_pkg::POS_W-1:0]       in_pos_x,
  input  wire logic signed [scpf_pkg::POS_W-1:0]       in_pos_y,
  input  wire logic signed [scpf_pkg::POS_W-1:0]       in_pos_z,
  input  wire logic [scpf_pkg::RAD_W-1:0]              in_radius,
  input  wire logic [scpf_pkg::LAYER_W-1:0]            in_attribute,
  input  wire logic [scpf_pkg::LAYER_W-1:0]            in_mask,
  input  wire logic [scpf_pkg::DMG_W-1:0]              in_damage,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic [scpf_pkg::OUT_IDX_W-1:0]               out_new_index,
  output logic [scpf_pkg::OUT_IDX_W-1:0]               out_other_index,
  output logic                                         out_hit_group,
  output logic [scpf_pkg::DMG_W-1:0]                   out_damage_to_new,
  output logic [scpf_pkg::DMG_W-1:0]                   out_damage_to_other,
  output logic                                         out_group_full,
  output logic                                         out_last
);

  localparam int IDX_W = $clog2(GROUP_CAPACITY);
  localparam int CNT_W = $clog2(GROUP_CAPACITY + 1);
  localparam int MEM_DEPTH = 2 * (2 ** IDX_W);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                   state_r;
  logic [IDX_W-1:0]       k_r;
  logic [IDX_W-1:0]       last_k_r;
  logic [CNT_W-1:0]       cnt_r [2];

  scpf_pkg::entry_t       mem [MEM_DEPTH];
  scpf_pkg::entry_t       rd_r;
  scpf_pkg::pair_ctl_t    rd_ctl_r;
  logic [IDX_W-1:0]       rd_k_r;

  scpf_pkg::entry_t       item_r;
  logic                   item_group_r;
  logic [IDX_W-1:0]       item_slot_r;

  logic                   pend_valid_r;
  logic                   pend_done_r;
  logic                   pend_full_r;
  logic [IDX_W-1:0]       pend_k_r;
  logic [scpf_pkg::DMG_W-1:0] pend_dmg_r;

  logic                   out_valid_r;
  logic [scpf_pkg::OUT_IDX_W-1:0] out_new_index_r, out_other_index_r;
  logic                   out_hit_group_r;
  logic [scpf_pkg::DMG_W-1:0] out_dtn_r, out_dto_r;
  logic                   out_full_r, out_last_r;

  scpf_pkg::entry_t       in_entry;
  scpf_pkg::pair_res_t    res;
  logic [IDX_W-1:0]       res_k;
  logic                   pipe_busy;
  logic                   adv;
  logic                   in_xfer;
  logic [CNT_W-1:0]       n_sel;
  logic                   sel_full;
  logic                   emit;
  logic                   emit_last;

  assign in_entry.pos_x     = in_pos_x;
  assign in_entry.pos_y     = in_pos_y;
  assign in_entry.pos_z     = in_pos_z;
  assign in_entry.radius    = in_radius;
  assign in_entry.attribute = in_attribute;
  assign in_entry.mask      = in_mask;
  assign in_entry.damage    = in_damage;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && !pipe_busy && !rd_ctl_r.valid && !pend_valid_r;
  assign in_xfer  = in_valid && in_ready;
  assign n_sel    = cnt_r[in_group];
  assign sel_full = n_sel >= CNT_W'(GROUP_CAPACITY);

  scpf_pair_test #(
    .IDX_W(IDX_W)
  ) u_pair_test (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .pair_ctl (rd_ctl_r),
    .pair_k   (rd_k_r),
    .stored   (rd_r),
    .fresh    (item_r),
    .res      (res),
    .res_k    (res_k),
    .busy     (pipe_busy)
  );

  always_ff @(posedge clk) begin
    if (in_xfer && in_opcode == scpf_pkg::OP_INSERT && !sel_full) begin
      mem[{in_group, n_sel[IDX_W-1:0]}] <= in_entry;
    end
    if (adv) begin
      rd_r   <= mem[{item_group_r, k_r}];
      rd_k_r <= k_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_opcode == scpf_pkg::OP_INSERT) begin
      item_r       <= in_entry;
      item_group_r <= in_group;
      item_slot_r  <= n_sel[IDX_W-1:0];
      last_k_r     <= IDX_W'(n_sel - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      k_r      <= '0;
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
      rd_ctl_r <= '0;
    end else begin
      if (adv) begin
        rd_ctl_r.valid      <= (state_r == ST_WALK);
        rd_ctl_r.final_pair <= (k_r == last_k_r);
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_opcode == scpf_pkg::OP_CLEAR) begin
              cnt_r[0] <= '0;
              cnt_r[1] <= '0;
            end else if (!sel_full) begin
              cnt_r[in_group] <= n_sel + CNT_W'(1);
              k_r <= '0;
              if (n_sel != '0) begin
                state_r <= ST_WALK;
              end
            end
          end
        end
        ST_WALK: begin
          if (adv) begin
            k_r <= k_r + IDX_W'(1);
            if (k_r == last_k_r) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    emit      = 1'b0;
    emit_last = 1'b0;
    if (adv) begin
      if (pend_valid_r && pend_done_r) begin
        emit      = 1'b1;
        emit_last = 1'b1;
      end else if (res.valid && pend_valid_r) begin
        if (res.hit) begin
          emit = 1'b1;
        end else if (res.final_pair) begin
          emit      = 1'b1;
          emit_last = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_done_r  <= 1'b0;
      pend_full_r  <= 1'b0;
    end else if (in_xfer && in_opcode == scpf_pkg::OP_INSERT && sel_full) begin
      pend_valid_r <= 1'b1;
      pend_done_r  <= 1'b1;
      pend_full_r  <= 1'b1;
    end else if (adv) begin
      if (pend_valid_r && pend_done_r) begin
        pend_valid_r <= 1'b0;
      end else if (res.valid && res.hit) begin
        pend_valid_r <= 1'b1;
        pend_done_r  <= res.final_pair;
        pend_full_r  <= 1'b0;
      end else if (res.valid && res.final_pair) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid && res.hit && !(pend_valid_r && pend_done_r)) begin
      pend_k_r   <= res_k;
      pend_dmg_r <= res.damage;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_hit_group_r <= item_group_r;
      out_full_r      <= pend_full_r;
      out_last_r      <= emit_last;
      if (pend_full_r) begin
        out_new_index_r   <= '0;
        out_other_index_r <= '0;
        out_dtn_r         <= '0;
        out_dto_r         <= '0;
      end else begin
        out_new_index_r   <= scpf_pkg::OUT_IDX_W'(item_slot_r);
        out_other_index_r <= scpf_pkg::OUT_IDX_W'(pend_k_r);
        out_dtn_r         <= pend_dmg_r;
        out_dto_r         <= item_r.damage;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_new_index       = out_new_index_r;
  assign out_other_index     = out_other_index_r;
  assign out_hit_group       = out_hit_group_r;
  assign out_damage_to_new   = out_dtn_r;
  assign out_damage_to_other = out_dto_r;
  assign out_group_full      = out_full_r;
  assign out_last            = out_last_r;

  a_full_pends: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_opcode == scpf_pkg::OP_INSERT && sel_full)
      |=> (pend_valid_r && pend_full_r && pend_done_r))
    else $error("full-group drop did not queue its flag result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] <= CNT_W'(GROUP_CAPACITY)) && (cnt_r[1] <= CNT_W'(GROUP_CAPACITY)))
    else $error("group count beyond capacity");

  a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_group_full) |-> out_last)
    else $error("group_full result without last");

  a_walk_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res.final_pair) |-> !in_ready)
    else $error("input accepted while a walk is in flight");

endmodule
`default_nettype wire

FILE: sv/scpf_pair_test.sv
`default_nettype none
module scpf_pair_test #(
  parameter int IDX_W = 5
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            adv,
  input  wire scpf_pkg::pair_ctl_t             pair_ctl,
  input  wire logic [IDX_W-1:0]                pair_k,
  input  wire scpf_pkg::entry_t                stored,
  input  wire scpf_pkg::entry_t                fresh,
  output scpf_pkg::pair_res_t                  res,
  output logic [IDX_W-1:0]                     res_k,
  output logic                                 busy
);

  scpf_pkg::pair_ctl_t                   a_ctl_r;
  logic [IDX_W-1:0]                      a_k_r;
  logic signed [scpf_pkg::DIFF_W-1:0]    a_dx_r, a_dy_r, a_dz_r;
  logic [scpf_pkg::RSUM_W-1:0]           a_rsum_r;
  logic                                  a_pass_r;
  logic [scpf_pkg::DMG_W-1:0]            a_dmg_r;

  scpf_pkg::pair_ctl_t                   b_ctl_r;
  logic [IDX_W-1:0]                      b_k_r;
  logic [scpf_pkg::SQ_W-1:0]             b_sqx_r, b_sqy_r, b_sqz_r;
  logic [scpf_pkg::RSQ_W-1:0]            b_rsq_r;
  logic                                  b_pass_r;
  logic [scpf_pkg::DMG_W-1:0]            b_dmg_r;

  scpf_pkg::pair_res_t                   res_r;
  logic [IDX_W-1:0]                      res_k_r;

  logic signed [scpf_pkg::DIFF_W-1:0]    dx, dy, dz;
  logic signed [2*scpf_pkg::DIFF_W-1:0]  px, py, pz;
  logic [scpf_pkg::DSQ_W-1:0]            dsq;

  assign dx = {fresh.pos_x[scpf_pkg::POS_W-1], fresh.pos_x}
            - {stored.pos_x[scpf_pkg::POS_W-1], stored.pos_x};
  assign dy = {fresh.pos_y[scpf_pkg::POS_W-1], fresh.pos_y}
            - {stored.pos_y[scpf_pkg::POS_W-1], stored.pos_y};
  assign dz = {fresh.pos_z[scpf_pkg::POS_W-1], fresh.pos_z}
            - {stored.pos_z[scpf_pkg::POS_W-1], stored.pos_z};

  assign px = a_dx_r * a_dx_r;
  assign py = a_dy_r * a_dy_r;
  assign pz = a_dz_r * a_dz_r;

  assign dsq = scpf_pkg::DSQ_W'(b_sqx_r) + scpf_pkg::DSQ_W'(b_sqy_r)
             + scpf_pkg::DSQ_W'(b_sqz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
      b_ctl_r <= '0;
      res_r   <= '0;
    end else if (adv) begin
      a_ctl_r <= pair_ctl;
      b_ctl_r <= a_ctl_r;
      res_r.valid      <= b_ctl_r.valid;
      res_r.final_pair <= b_ctl_r.final_pair;
      res_r.hit        <= b_pass_r && (dsq <= scpf_pkg::DSQ_W'(b_rsq_r));
      res_r.damage     <= b_dmg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_k_r    <= pair_k;
      a_dx_r   <= dx;
      a_dy_r   <= dy;
      a_dz_r   <= dz;
      a_rsum_r <= scpf_pkg::RSUM_W'(stored.radius) + scpf_pkg::RSUM_W'(fresh.radius);
      a_pass_r <= ((stored.attribute & fresh.mask) != '0)
               && ((fresh.attribute & stored.mask) != '0);
      a_dmg_r  <= stored.damage;
      b_k_r    <= a_k_r;
      b_sqx_r  <= px[scpf_pkg::SQ_W-1:0];
      b_sqy_r  <= py[scpf_pkg::SQ_W-1:0];
      b_sqz_r  <= pz[scpf_pkg::SQ_W-1:0];
      b_rsq_r  <= a_rsum_r * a_rsum_r;
      b_pass_r <= a_pass_r;
      b_dmg_r  <= a_dmg_r;
      res_k_r  <= b_k_r;
    end
  end

  assign res   = res_r;
  assign res_k = res_k_r;
  assign busy  = a_ctl_r.valid || b_ctl_r.valid || res_r.valid;

endmodule
`default_nettype wire
